>>> hdl/xor_packet_deframer_macros.svh
// Assertion macros shared by the deframer's checker.
`ifndef XOR_PACKET_DEFRAMER_MACROS_SVH
`define XOR_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XPD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XPD_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/xpd_pkg.sv
// Types and constants shared by the XOR packet deframer modules.
package xpd_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;

    // Configuration port.
    localparam int               PADDR_W          = 3;
    localparam logic [0:0]       REG_HEADER_VALUE = 1'b0;
    localparam logic [7:0]       HEADER_VALUE_RST = 8'hAA;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK,
        PH_DONE,
        PH_FAIL
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SINGLE,
        SQ_FETCH,
        SQ_LOAD
    } seq_state_t;

    // Outcome of a buffer, handed from the parser to the readout on the final beat.
    typedef struct packed {
        logic       done;
        logic       ok;
        logic [7:0] length;
        logic [7:0] checksum;
    } frame_result_t;

endpackage

>>> hdl/xpd_ifs.sv
// Valid/ready channel interfaces for received bytes and decoded results.
interface xpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_buffer;

    modport source (output valid, rx_byte, end_of_buffer, input ready);
    modport sink   (input valid, rx_byte, end_of_buffer, output ready);
endinterface

interface xpd_result_if;
    logic       valid;
    logic       ready;
    logic       frame_ok;
    logic [5:0] payload_length;
    logic [7:0] frame_checksum;
    logic       has_byte;
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic       last;

    modport source (output valid, frame_ok, payload_length, frame_checksum, has_byte,
                    payload_byte, byte_index, last, input ready);
    modport sink   (input valid, frame_ok, payload_length, frame_checksum, has_byte,
                    payload_byte, byte_index, last, output ready);
endinterface

>>> hdl/xor_packet_deframer.sv
// Bytes of a received buffer come in on rx, one per beat, the final one flagged by
// end_of_buffer. After every byte that is not final, rx stays ready for the next one.
// On the final byte the block reports through res: a single beat on failure or on an
// empty payload, otherwise one beat per payload byte. rx is held off until that run has
// been handed to the output register; each payload beat is a read of the payload memory,
// then a load of the output register; payload beats and single-beat reports alike wait
// out any stall on res. The payload memory is not cleared after reset, and only entries
// written by the current frame are read back.
// header_value lies at byte address 0 of the register port and resets to 0xAA.
module xor_packet_deframer
    import xpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    xpd_byte_if.sink           rx,
    xpd_result_if.source       res
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]        header_value_reg;
    logic [0:0]        reg_index;
    logic              cfg_write;
    logic              beat_accept;
    logic              seq_idle;
    frame_result_t     result;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    assign reg_index = paddr[2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_value_reg <= HEADER_VALUE_RST;
        end
        else if (cfg_write && (reg_index == REG_HEADER_VALUE))
        begin
            header_value_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_HEADER_VALUE: prdata = {24'd0, header_value_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign rx.ready    = seq_idle;
    assign beat_accept = rx.valid && seq_idle;

    xpd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .header_value  (header_value_reg),
        .beat_valid    (beat_accept),
        .rx_byte       (rx.rx_byte),
        .end_of_buffer (rx.end_of_buffer),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .result        (result)
    );

    xpd_ram #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    xpd_readout #(
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_readout (
        .clk     (clk),
        .rst_n   (rst_n),
        .result  (result),
        .rd_data (rd_data),
        .idle    (seq_idle),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .res     (res)
    );

endmodule

>>> hdl/xpd_ram.sv
// Payload store: one write port, one read port with registered read data.
module xpd_ram
    import xpd_pkg::*;
#(
    parameter int DEPTH  = MAX_PAYLOAD_DEF,
    parameter int ADDR_W = $clog2(MAX_PAYLOAD_DEF)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/xpd_parser.sv
// Frame parser: walks header, length, payload and checksum one beat at a time.
module xpd_parser
    import xpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int ADDR_W      = $clog2(MAX_PAYLOAD_DEF),
    parameter int CNT_W       = $clog2(MAX_PAYLOAD_DEF + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        header_value,
    input  logic              beat_valid,
    input  logic [7:0]        rx_byte,
    input  logic              end_of_buffer,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output frame_result_t     result
);

    phase_t           phase_reg, phase_next, phase_adv;
    logic [CNT_W-1:0] count_reg, count_next, count_adv, count_inc;
    logic [7:0]       len_reg, len_next, len_adv;
    logic [7:0]       xor_reg, xor_next, xor_adv;
    logic [7:0]       check_reg, check_next, check_adv;

    assign count_inc = count_reg + CNT_W'(1);

    // Next state: absorb the beat, then rearm on the final beat of a buffer.
    always_comb
    begin
        phase_adv = phase_reg;
        count_adv = count_reg;
        len_adv   = len_reg;
        xor_adv   = xor_reg;
        check_adv = check_reg;
        if (beat_valid)
        begin
            unique case (phase_reg) inside
                PH_HEADER:
                begin
                    if (rx_byte == header_value)
                    begin
                        xor_adv   = rx_byte;
                        phase_adv = PH_LENGTH;
                    end
                    else
                    begin
                        phase_adv = PH_FAIL;
                    end
                end
                PH_LENGTH:
                begin
                    if (rx_byte > 8'(MAX_PAYLOAD))
                    begin
                        phase_adv = PH_FAIL;
                    end
                    else
                    begin
                        len_adv   = rx_byte;
                        xor_adv   = xor_reg ^ rx_byte;
                        count_adv = '0;
                        phase_adv = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    xor_adv   = xor_reg ^ rx_byte;
                    count_adv = count_inc;
                    if (8'(count_inc) >= len_reg)
                    begin
                        phase_adv = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    check_adv = rx_byte;
                    phase_adv = (rx_byte == xor_reg) ? PH_DONE : PH_FAIL;
                end
                PH_DONE, PH_FAIL:
                begin
                end
                default:
                begin
                    phase_adv = PH_FAIL;
                end
            endcase
        end

        if (beat_valid && end_of_buffer)
        begin
            phase_next = PH_HEADER;
            count_next = '0;
            len_next   = '0;
            xor_next   = '0;
            check_next = '0;
        end
        else
        begin
            phase_next = phase_adv;
            count_next = count_adv;
            len_next   = len_adv;
            xor_next   = xor_adv;
            check_next = check_adv;
        end
    end

    // Outputs: payload write and the buffer outcome.
    always_comb
    begin
        wr_en           = beat_valid && (phase_reg == PH_PAYLOAD);
        wr_addr         = count_reg[ADDR_W-1:0];
        wr_data         = rx_byte;
        result.done     = beat_valid && end_of_buffer;
        result.ok       = (phase_adv == PH_DONE);
        result.length   = len_adv;
        result.checksum = check_adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            count_reg <= '0;
            len_reg   <= '0;
            xor_reg   <= '0;
            check_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            xor_reg   <= xor_next;
            check_reg <= check_next;
        end
    end

endmodule

>>> hdl/xpd_readout.sv
// Readout sequencer: turns a buffer outcome into result beats, reading the payload store.
module xpd_readout
    import xpd_pkg::*;
#(
    parameter int ADDR_W      = $clog2(MAX_PAYLOAD_DEF),
    parameter int CNT_W       = $clog2(MAX_PAYLOAD_DEF + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  frame_result_t       result,
    input  logic [7:0]          rd_data,
    output logic                idle,
    output logic                rd_en,
    output logic [ADDR_W-1:0]   rd_addr,
    xpd_result_if.source        res
);

    seq_state_t       state_reg, state_next;
    logic             ok_reg;
    logic [7:0]       len_reg;
    logic [7:0]       chk_reg;
    logic [CNT_W-1:0] idx_reg, idx_inc;
    logic             run_last;

    logic             out_valid_reg;
    logic             out_ok_reg;
    logic [5:0]       out_len_reg;
    logic [7:0]       out_chk_reg;
    logic             out_has_reg;
    logic [7:0]       out_byte_reg;
    logic [4:0]       out_idx_reg;
    logic             out_last_reg;

    logic             out_free;
    logic             load_single;
    logic             load_byte;

    assign idx_inc  = idx_reg + CNT_W'(1);
    assign run_last = (8'(idx_inc) == len_reg);
    // The output register is empty after this edge.
    assign out_free = !out_valid_reg || res.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE:
            begin
                if (result.done)
                begin
                    if (!result.ok || (result.length == 8'd0))
                    begin
                        state_next = SQ_SINGLE;
                    end
                    else
                    begin
                        state_next = SQ_FETCH;
                    end
                end
            end
            SQ_SINGLE:
            begin
                if (out_free)
                begin
                    state_next = SQ_IDLE;
                end
            end
            SQ_FETCH:
            begin
                if (out_free)
                begin
                    state_next = SQ_LOAD;
                end
            end
            SQ_LOAD:
            begin
                state_next = run_last ? SQ_IDLE : SQ_FETCH;
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idle        = (state_reg == SQ_IDLE);
        rd_en       = (state_reg == SQ_FETCH) && out_free;
        rd_addr     = idx_reg[ADDR_W-1:0];
        load_single = (state_reg == SQ_SINGLE) && out_free;
        load_byte   = (state_reg == SQ_LOAD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_single || load_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (result.done)
            begin
                idx_reg <= '0;
            end
            else if (load_byte)
            begin
                idx_reg <= idx_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.done)
        begin
            ok_reg  <= result.ok;
            len_reg <= result.ok ? result.length : 8'd0;
            chk_reg <= result.ok ? result.checksum : 8'd0;
        end
        if (load_single)
        begin
            out_ok_reg   <= ok_reg;
            out_len_reg  <= 6'(len_reg);
            out_chk_reg  <= chk_reg;
            out_has_reg  <= 1'b0;
            out_byte_reg <= 8'd0;
            out_idx_reg  <= 5'd0;
            out_last_reg <= 1'b1;
        end
        else if (load_byte)
        begin
            out_ok_reg   <= ok_reg;
            out_len_reg  <= 6'(len_reg);
            out_chk_reg  <= chk_reg;
            out_has_reg  <= 1'b1;
            out_byte_reg <= rd_data;
            out_idx_reg  <= 5'(idx_reg);
            out_last_reg <= run_last;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.frame_ok       = out_ok_reg;
    assign res.payload_length = out_len_reg;
    assign res.frame_checksum = out_chk_reg;
    assign res.has_byte       = out_has_reg;
    assign res.payload_byte   = out_byte_reg;
    assign res.byte_index     = out_idx_reg;
    assign res.last           = out_last_reg;

endmodule

>>> hdl/xpd_checker.sv
// Port-level checks of the deframer, bound to its top level.
`include "xor_packet_deframer_macros.svh"

module xpd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_end,
    input logic       out_valid,
    input logic       out_ready,
    input logic       frame_ok,
    input logic [5:0] payload_length,
    input logic [7:0] frame_checksum,
    input logic       has_byte,
    input logic [7:0] payload_byte,
    input logic       last
);

    // The final beat of a buffer always starts a report, which holds off input.
    `XPD_ASSERT_NXT(a_final_beat_blocks, clk, rst_n, in_valid && in_ready && in_end, !in_ready, "input ready right after a final beat")

    // While a run of payload beats is under way, no new byte is taken.
    `XPD_ASSERT_IMP(a_run_blocks_input, clk, rst_n, out_valid && !last, !in_ready, "input ready in the middle of a payload run")

    // A failure report is a single beat, marked last, with its length, checksum and byte fields cleared.
    `XPD_ASSERT_IMP(a_failure_clean, clk, rst_n, out_valid && !frame_ok, (payload_length == 6'd0) && (frame_checksum == 8'd0) && !has_byte && last, "failure beat carries data")

    // A stalled result beat keeps its payload byte.
    `XPD_ASSERT_NXT(a_result_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(payload_byte), "stalled result beat changed")

endmodule

bind xor_packet_deframer xpd_checker u_xpd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (rx.valid),
    .in_ready       (rx.ready),
    .in_end         (rx.end_of_buffer),
    .out_valid      (res.valid),
    .out_ready      (res.ready),
    .frame_ok       (res.frame_ok),
    .payload_length (res.payload_length),
    .frame_checksum (res.frame_checksum),
    .has_byte       (res.has_byte),
    .payload_byte   (res.payload_byte),
    .last           (res.last)
);
